[hw/rtl/twta_pkg.sv]
package twta_pkg;

  typedef enum logic [1:0] {
    ADDR_BORDER,
    ADDR_CLAMP,
    ADDR_REPEAT,
    ADDR_MIRROR
  } twta_wrap_t;

  localparam logic [2:0] REG_BASE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_BASE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_TILE_W_LOG2 = 3'd2;
  localparam logic [2:0] REG_TILE_H_LOG2 = 3'd3;
  localparam logic [2:0] REG_S_WRAP      = 3'd4;
  localparam logic [2:0] REG_T_WRAP      = 3'd5;
  localparam logic [2:0] REG_CHANNELS    = 3'd6;
  localparam logic [2:0] REG_FIRST_CHAN  = 3'd7;

  localparam int TILE_LOG2_MAX = 10;

  typedef struct packed {
    logic [14:0] base_width;
    logic [14:0] base_height;
    logic [3:0]  tw_log2;
    logic [3:0]  th_log2;
    twta_wrap_t  s_mode;
    twta_wrap_t  t_mode;
    logic [4:0]  channel_count;
    logic [3:0]  first_channel;
  } twta_cfg_t;

  typedef struct packed {
    logic [13:0] c0;
    logic [13:0] c1;
    logic        v0;
    logic        v1;
    logic        one;
  } twta_axis_t;

  typedef struct packed {
    twta_axis_t  s;
    twta_axis_t  t;
    logic [15:0] frac_s;
    logic [15:0] frac_t;
    logic [3:0]  level;
  } twta_item_t;

endpackage

[hw/rtl/twta_if.sv]
interface twta_lookup_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] s_coord;
  logic signed [23:0] t_coord;
  logic [3:0]         mip_level;

  modport source (output valid, s_coord, t_coord, mip_level, input ready);
  modport sink (input valid, s_coord, t_coord, mip_level, output ready);
endinterface

interface twta_corner_if;
  logic        valid;
  logic        ready;
  logic [1:0]  corner_index;
  logic        texel_valid;
  logic [13:0] tile_origin_x;
  logic [13:0] tile_origin_y;
  logic [3:0]  level_out;
  logic [24:0] element_offset;
  logic [15:0] frac_s;
  logic [15:0] frac_t;
  logic        same_tile;
  logic        last_corner;

  modport source (output valid, corner_index, texel_valid, tile_origin_x, tile_origin_y,
                  level_out, element_offset, frac_s, frac_t, same_tile, last_corner,
                  input ready);
  modport sink (input valid, corner_index, texel_valid, tile_origin_x, tile_origin_y,
                level_out, element_offset, frac_s, frac_t, same_tile, last_corner,
                output ready);
endinterface

[hw/rtl/twta_rem.sv]
module twta_rem #(
  parameter int N  = 24,
  parameter int MW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [N-1:0]  din,
  input  logic [MW-1:0] m,
  output logic [MW-1:0] rem
);

  logic [MW-1:0] r_q [N];
  logic [N-1:0]  d_q [N];
  logic [MW-1:0] m_q [N];
  logic [MW-1:0] r_n [N];
  logic [N-1:0]  d_n [N];
  logic [MW-1:0] m_n [N];

  always_comb begin
    logic [MW-1:0] rp;
    logic [N-1:0]  dp;
    logic [MW-1:0] mp;
    logic [MW:0]   t;
    for (int k = 0; k < N; k++) begin
      rp = (k == 0) ? '0 : r_q[(k == 0) ? 0 : k-1];
      dp = (k == 0) ? din : d_q[(k == 0) ? 0 : k-1];
      mp = (k == 0) ? m : m_q[(k == 0) ? 0 : k-1];
      t = {rp, dp[N-1]};
      if (t >= {1'b0, mp}) begin
        t = t - {1'b0, mp};
      end
      r_n[k] = t[MW-1:0];
      d_n[k] = dp << 1;
      m_n[k] = mp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_q <= r_n;
      d_q <= d_n;
      m_q <= m_n;
    end
  end

  assign rem = r_q[N-1];

endmodule

[hw/rtl/twta_front.sv]
module twta_front import twta_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_SIZE_LOG2 = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  twta_cfg_t  cfg,
  twta_lookup_if.sink lookup,
  output logic       push,
  output twta_item_t item,
  input  logic       fifo_ready
);

  localparam int SZW  = MAX_SIZE_LOG2 + 1;
  localparam int MW   = SZW + 1;
  localparam int SS_W = 24 + SZW + 1;
  localparam int SI_W = SS_W - FRAC_BITS;
  localparam int XW   = (SI_W + 2 > 16) ? SI_W + 2 : 16;
  localparam logic signed [SS_W-1:0] HALF = SS_W'(1) << (FRAC_BITS - 1);

  function automatic logic [SZW-1:0] lvl_size(logic [14:0] base, logic [3:0] lvl);
    logic [14:0] sh;
    logic [SZW-1:0] res;
    sh = base >> lvl;
    if (sh == '0) begin
      res = SZW'(1);
    end else if (32'(sh) > (32'd1 << MAX_SIZE_LOG2)) begin
      res = SZW'(32'd1 << MAX_SIZE_LOG2);
    end else begin
      res = SZW'(sh);
    end
    return res;
  endfunction

  function automatic logic [15:0] frac16(logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+15:0] fx;
    fx = {f, 16'b0};
    return fx[FRAC_BITS+15 -: 16];
  endfunction

  function automatic logic [MW-1:0] modulus(twta_wrap_t mode, logic [SZW-1:0] w);
    return (mode == ADDR_MIRROR) ? {w, 1'b0} : {1'b0, w};
  endfunction

  function automatic twta_axis_t wrap_axis(twta_wrap_t mode, logic signed [SI_W-1:0] v,
                                           logic [MW-1:0] r, logic [SZW-1:0] w,
                                           logic [MW-1:0] m, logic [3:0] tl);
    logic signed [XW-1:0] v0, v1, wx, mx, rx, fm, f1, c0, c1;
    logic ok0, ok1;
    logic [9:0] tm;
    twta_axis_t a;
    v0 = XW'(v);
    v1 = v0 + 1;
    wx = XW'(w);
    mx = XW'(m);
    rx = XW'(r);
    fm = (v0 < 0 && rx != 0) ? mx - rx : rx;
    ok0 = 1'b1;
    ok1 = 1'b1;
    case (mode)
      ADDR_BORDER: begin
        c0 = v0;
        c1 = v1;
        ok0 = (v0 >= 0) && (v0 < wx);
        ok1 = (v1 >= 0) && (v1 < wx);
      end
      ADDR_CLAMP: begin
        c0 = (v0 < 0) ? '0 : ((v0 >= wx) ? wx - 1 : v0);
        c1 = (v1 < 0) ? '0 : ((v1 >= wx) ? wx - 1 : v1);
      end
      ADDR_REPEAT: begin
        c0 = fm;
        c1 = (fm + 1 == wx) ? '0 : fm + 1;
      end
      default: begin
        f1 = (fm + 1 == mx) ? '0 : fm + 1;
        c0 = (fm < wx) ? fm : mx - 1 - fm;
        c1 = (f1 < wx) ? f1 : mx - 1 - f1;
      end
    endcase
    tm = 10'((11'd1 << tl) - 11'd1);
    a.c0 = c0[13:0];
    a.c1 = c1[13:0];
    a.v0 = ok0;
    a.v1 = ok1;
    a.one = ok0 && ok1 && ((c0[9:0] & tm) != tm) && (c0 + 1 == c1);
    return a;
  endfunction

  logic en;

  logic                   s0_v;
  logic signed [SS_W-1:0] ps, pt;
  logic [3:0]             lvl0;
  logic [SZW-1:0]         w0, h0;

  logic                   s1_v;
  logic signed [SI_W-1:0] si_s, si_t;
  logic [15:0]            fs1, ft1;
  logic [3:0]             lvl1;
  logic [SZW-1:0]         w1, h1;

  logic                   sb_v   [SI_W];
  logic signed [SI_W-1:0] sb_s   [SI_W];
  logic signed [SI_W-1:0] sb_t   [SI_W];
  logic [15:0]            sb_fs  [SI_W];
  logic [15:0]            sb_ft  [SI_W];
  logic [3:0]             sb_lvl [SI_W];
  logic [SZW-1:0]         sb_w   [SI_W];
  logic [SZW-1:0]         sb_h   [SI_W];

  logic                   wv;
  logic [MW-1:0]          rem_s, rem_t;
  logic [SZW-1:0]         wi, hi;
  logic signed [SS_W-1:0] ss, ts;
  logic [SI_W-1:0]        mag_s, mag_t;

  assign en = !wv || fifo_ready;
  assign lookup.ready = en;
  assign push = wv && fifo_ready;

  assign wi = lvl_size(cfg.base_width, lookup.mip_level);
  assign hi = lvl_size(cfg.base_height, lookup.mip_level);
  assign ss = ps - HALF;
  assign ts = pt - HALF;
  assign mag_s = (si_s < 0) ? SI_W'(-si_s) : SI_W'(si_s);
  assign mag_t = (si_t < 0) ? SI_W'(-si_t) : SI_W'(si_t);

  twta_rem #(.N(SI_W), .MW(MW)) u_rem_s (
    .clk (clk),
    .en  (en),
    .din (mag_s),
    .m   (modulus(cfg.s_mode, w1)),
    .rem (rem_s)
  );

  twta_rem #(.N(SI_W), .MW(MW)) u_rem_t (
    .clk (clk),
    .en  (en),
    .din (mag_t),
    .m   (modulus(cfg.t_mode, h1)),
    .rem (rem_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      wv   <= 1'b0;
      for (int k = 0; k < SI_W; k++) begin
        sb_v[k] <= 1'b0;
      end
    end else if (en) begin
      s0_v <= lookup.valid;
      s1_v <= s0_v;
      sb_v[0] <= s1_v;
      for (int k = 1; k < SI_W; k++) begin
        sb_v[k] <= sb_v[k-1];
      end
      wv <= sb_v[SI_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps   <= SS_W'(lookup.s_coord) * SS_W'($signed({1'b0, wi}));
      pt   <= SS_W'(lookup.t_coord) * SS_W'($signed({1'b0, hi}));
      lvl0 <= lookup.mip_level;
      w0   <= wi;
      h0   <= hi;

      si_s <= ss[SS_W-1:FRAC_BITS];
      si_t <= ts[SS_W-1:FRAC_BITS];
      fs1  <= frac16(ss[FRAC_BITS-1:0]);
      ft1  <= frac16(ts[FRAC_BITS-1:0]);
      lvl1 <= lvl0;
      w1   <= w0;
      h1   <= h0;

      sb_s[0]   <= si_s;
      sb_t[0]   <= si_t;
      sb_fs[0]  <= fs1;
      sb_ft[0]  <= ft1;
      sb_lvl[0] <= lvl1;
      sb_w[0]   <= w1;
      sb_h[0]   <= h1;
      for (int k = 1; k < SI_W; k++) begin
        sb_s[k]   <= sb_s[k-1];
        sb_t[k]   <= sb_t[k-1];
        sb_fs[k]  <= sb_fs[k-1];
        sb_ft[k]  <= sb_ft[k-1];
        sb_lvl[k] <= sb_lvl[k-1];
        sb_w[k]   <= sb_w[k-1];
        sb_h[k]   <= sb_h[k-1];
      end

      item.s <= wrap_axis(cfg.s_mode, sb_s[SI_W-1], rem_s, sb_w[SI_W-1],
                          modulus(cfg.s_mode, sb_w[SI_W-1]), cfg.tw_log2);
      item.t <= wrap_axis(cfg.t_mode, sb_t[SI_W-1], rem_t, sb_h[SI_W-1],
                          modulus(cfg.t_mode, sb_h[SI_W-1]), cfg.th_log2);
      item.frac_s <= sb_fs[SI_W-1];
      item.frac_t <= sb_ft[SI_W-1];
      item.level  <= sb_lvl[SI_W-1];
    end
  end

endmodule

[hw/rtl/twta_fifo.sv]
module twta_fifo import twta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  twta_item_t din,
  output logic       ready,
  output logic       valid,
  output twta_item_t dout,
  input  logic       pop
);

  twta_item_t mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

endmodule

[hw/rtl/twta_back.sv]
module twta_back import twta_pkg::*; #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  twta_cfg_t  cfg,
  input  logic       valid,
  input  twta_item_t item,
  output logic       pop,
  twta_corner_if.source corner
);

  localparam int NCH_W = $clog2(MAX_CHANNELS + 1);
  localparam int OW    = 20 + NCH_W + 1;

  logic [1:0]       cnt;
  logic             ld;
  logic [13:0]      x, y;
  logic             tex_ok;
  logic [9:0]       tmw, tmh, ix, iy;
  logic [19:0]      idx;
  logic [NCH_W-1:0] nch;
  logic [OW-1:0]    off;

  assign ld  = valid && (!corner.valid || corner.ready);
  assign pop = ld && (cnt == 2'd3);

  assign x      = cnt[0] ? item.s.c1 : item.s.c0;
  assign y      = cnt[1] ? item.t.c1 : item.t.c0;
  assign tex_ok = (cnt[0] ? item.s.v1 : item.s.v0) && (cnt[1] ? item.t.v1 : item.t.v0);
  assign tmw    = 10'((11'd1 << cfg.tw_log2) - 11'd1);
  assign tmh    = 10'((11'd1 << cfg.th_log2) - 11'd1);
  assign ix     = x[9:0] & tmw;
  assign iy     = y[9:0] & tmh;
  assign idx    = (20'(iy) << cfg.tw_log2) | 20'(ix);
  assign nch    = (32'(cfg.channel_count) > MAX_CHANNELS) ? NCH_W'(MAX_CHANNELS)
                                                          : NCH_W'(cfg.channel_count);
  assign off    = OW'(idx) * OW'(nch) + OW'(cfg.first_channel);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner.valid <= 1'b0;
      cnt          <= 2'd0;
    end else if (ld) begin
      corner.valid          <= 1'b1;
      cnt                   <= cnt + 2'd1;
      corner.corner_index   <= cnt;
      corner.texel_valid    <= tex_ok;
      corner.tile_origin_x  <= tex_ok ? (x & ~{4'b0, tmw}) : '0;
      corner.tile_origin_y  <= tex_ok ? (y & ~{4'b0, tmh}) : '0;
      corner.level_out      <= item.level;
      corner.element_offset <= tex_ok ? 25'(off) : '0;
      corner.frac_s         <= item.frac_s;
      corner.frac_t         <= item.frac_t;
      corner.same_tile      <= item.s.one && item.t.one;
      corner.last_corner    <= (cnt == 2'd3);
    end else if (corner.ready) begin
      corner.valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/texel_wrap_and_tile_address_core.sv]
// channel   dir  role
// lookup    in   s_coord, t_coord, mip_level: one transaction per lookup
// corner    out  four transactions per lookup, corners 0..3, last_corner on 3
// apb       in   eight config registers at 4*i, pready tied high
//
// Sustained rate: set by the corner sequencer, which emits four corners per
// lookup, one corner per cycle while the queue holds an item and no corner
// is held back by corner.ready. The remainder pipeline takes one quotient
// bit per stage. rst clears all valid state. A two-entry queue parts the
// front pipeline from the sequencer; a full queue stalls the front and drops
// lookup.ready when the front holds a finished item.
module texel_wrap_and_tile_address_core import twta_pkg::*; #(
  parameter int FRAC_BITS     = 16,
  parameter int MAX_SIZE_LOG2 = 14,
  parameter int MAX_CHANNELS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  twta_lookup_if.sink   lookup,
  twta_corner_if.source corner
);

  logic [14:0] base_width, base_height;
  logic [3:0]  tile_width_log2, tile_height_log2;
  logic [1:0]  s_wrap_mode, t_wrap_mode;
  logic [4:0]  channel_count;
  logic [3:0]  first_channel;
  twta_cfg_t   cfg;
  logic        wr;

  logic       push, fifo_ready, q_valid, pop;
  twta_item_t f_item, q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_width       <= 15'd256;
      base_height      <= 15'd256;
      tile_width_log2  <= 4'd6;
      tile_height_log2 <= 4'd6;
      s_wrap_mode      <= 2'd0;
      t_wrap_mode      <= 2'd0;
      channel_count    <= 5'd4;
      first_channel    <= 4'd0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_BASE_WIDTH:  base_width       <= pwdata[14:0];
        REG_BASE_HEIGHT: base_height      <= pwdata[14:0];
        REG_TILE_W_LOG2: tile_width_log2  <= pwdata[3:0];
        REG_TILE_H_LOG2: tile_height_log2 <= pwdata[3:0];
        REG_S_WRAP:      s_wrap_mode      <= pwdata[1:0];
        REG_T_WRAP:      t_wrap_mode      <= pwdata[1:0];
        REG_CHANNELS:    channel_count    <= pwdata[4:0];
        REG_FIRST_CHAN:  first_channel    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BASE_WIDTH:  prdata = 32'(base_width);
      REG_BASE_HEIGHT: prdata = 32'(base_height);
      REG_TILE_W_LOG2: prdata = 32'(tile_width_log2);
      REG_TILE_H_LOG2: prdata = 32'(tile_height_log2);
      REG_S_WRAP:      prdata = 32'(s_wrap_mode);
      REG_T_WRAP:      prdata = 32'(t_wrap_mode);
      REG_CHANNELS:    prdata = 32'(channel_count);
      REG_FIRST_CHAN:  prdata = 32'(first_channel);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.base_width    = base_width;
    cfg.base_height   = base_height;
    cfg.tw_log2       = (tile_width_log2 > 4'(TILE_LOG2_MAX)) ? 4'(TILE_LOG2_MAX)
                                                              : tile_width_log2;
    cfg.th_log2       = (tile_height_log2 > 4'(TILE_LOG2_MAX)) ? 4'(TILE_LOG2_MAX)
                                                               : tile_height_log2;
    cfg.s_mode        = twta_wrap_t'(s_wrap_mode);
    cfg.t_mode        = twta_wrap_t'(t_wrap_mode);
    cfg.channel_count = channel_count;
    cfg.first_channel = first_channel;
  end

  twta_front #(.FRAC_BITS(FRAC_BITS), .MAX_SIZE_LOG2(MAX_SIZE_LOG2)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .lookup     (lookup),
    .push       (push),
    .item       (f_item),
    .fifo_ready (fifo_ready)
  );

  twta_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_item),
    .ready (fifo_ready),
    .valid (q_valid),
    .dout  (q_item),
    .pop   (pop)
  );

  twta_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .valid  (q_valid),
    .item   (q_item),
    .pop    (pop),
    .corner (corner)
  );

endmodule

[verif/twta_tb_if.sv]
interface twta_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
endinterface

[verif/twta_checker.sv]
module twta_checker import twta_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  twta_lookup_if      lookup,
  twta_corner_if      corner,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  corner_index;
    logic        texel_valid;
    logic [13:0] tile_origin_x;
    logic [13:0] tile_origin_y;
    logic [3:0]  level_out;
    logic [24:0] element_offset;
    logic [15:0] frac_s;
    logic [15:0] frac_t;
    logic        same_tile;
    logic        last_corner;
  } texel_addr_t;

  twta_cfg_t   cfg;
  texel_addr_t expected_texels[$];

  assign pending = expected_texels.size();

  function automatic longint level_dim(logic [14:0] base, logic [3:0] lvl);
    longint sz;
    sz = longint'(base) >> lvl;
    if (sz < 1) sz = 1;
    if (sz > 16384) sz = 16384;
    return sz;
  endfunction

  function automatic longint floor_div(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d != 0) && (v < 0)) q = q - 1;
    return q;
  endfunction

  function automatic logic wrap_coord(twta_wrap_t mode, ref longint c, input longint w);
    longint m;
    case (mode)
      ADDR_BORDER: return (c >= 0) && (c < w);
      ADDR_CLAMP: begin
        if (c < 0) c = 0;
        else if (c >= w) c = w - 1;
      end
      ADDR_REPEAT: begin
        c = c - floor_div(c, w) * w;
      end
      default: begin
        m = c - floor_div(c, 2 * w) * 2 * w;
        c = (m < w) ? m : 2 * w - 1 - m;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic predict_texels(logic signed [23:0] s, logic signed [23:0] t, logic [3:0] lvl);
    longint w, h, ss, ts, twm, thm, nch, x, y, ix, iy;
    longint sx[2], ty[2];
    logic sv[2], tv[2];
    logic s_one, t_one, one;
    int twl, thl;
    texel_addr_t e;
    w = level_dim(cfg.base_width, lvl);
    h = level_dim(cfg.base_height, lvl);
    ss = longint'(s) * w - 32768;
    ts = longint'(t) * h - 32768;
    twl = (cfg.tw_log2 > TILE_LOG2_MAX) ? TILE_LOG2_MAX : cfg.tw_log2;
    thl = (cfg.th_log2 > TILE_LOG2_MAX) ? TILE_LOG2_MAX : cfg.th_log2;
    twm = (longint'(1) << twl) - 1;
    thm = (longint'(1) << thl) - 1;
    nch = (cfg.channel_count > 16) ? 16 : cfg.channel_count;
    sx[0] = ss >>> 16; sx[1] = sx[0] + 1;
    ty[0] = ts >>> 16; ty[1] = ty[0] + 1;
    for (int i = 0; i < 2; i++) begin
      sv[i] = wrap_coord(cfg.s_mode, sx[i], w);
      tv[i] = wrap_coord(cfg.t_mode, ty[i], h);
    end
    s_one = ((sx[0] & twm) != twm) && (sx[0] + 1 == sx[1]);
    t_one = ((ty[0] & thm) != thm) && (ty[0] + 1 == ty[1]);
    one = s_one && t_one && sv[0] && sv[1] && tv[0] && tv[1];
    for (int j = 0; j < 2; j++) begin
      for (int i = 0; i < 2; i++) begin
        e = '0;
        e.corner_index = 2'(j * 2 + i);
        e.texel_valid = sv[i] && tv[j];
        if (e.texel_valid) begin
          x = sx[i]; y = ty[j];
          ix = x & twm; iy = y & thm;
          e.tile_origin_x = 14'(x - ix);
          e.tile_origin_y = 14'(y - iy);
          e.element_offset = 25'(nch * ((iy << twl) + ix) + cfg.first_channel);
        end
        e.level_out = lvl;
        e.frac_s = ss[15:0];
        e.frac_t = ts[15:0];
        e.same_tile = one;
        e.last_corner = (j == 1) && (i == 1);
        expected_texels.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    fail_count++;
  endtask

  texel_addr_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      cfg.base_width <= 15'd256;
      cfg.base_height <= 15'd256;
      cfg.tw_log2 <= 4'd6;
      cfg.th_log2 <= 4'd6;
      cfg.s_mode <= ADDR_BORDER;
      cfg.t_mode <= ADDR_BORDER;
      cfg.channel_count <= 5'd4;
      cfg.first_channel <= 4'd0;
      expected_texels.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_BASE_WIDTH:  cfg.base_width <= pwdata[14:0];
          REG_BASE_HEIGHT: cfg.base_height <= pwdata[14:0];
          REG_TILE_W_LOG2: cfg.tw_log2 <= pwdata[3:0];
          REG_TILE_H_LOG2: cfg.th_log2 <= pwdata[3:0];
          REG_S_WRAP:      cfg.s_mode <= twta_wrap_t'(pwdata[1:0]);
          REG_T_WRAP:      cfg.t_mode <= twta_wrap_t'(pwdata[1:0]);
          REG_CHANNELS:    cfg.channel_count <= pwdata[4:0];
          REG_FIRST_CHAN:  cfg.first_channel <= pwdata[3:0];
          default: ;
        endcase
      end
      if (corner.valid && corner.ready) begin
        got = {corner.corner_index, corner.texel_valid, corner.tile_origin_x,
               corner.tile_origin_y, corner.level_out, corner.element_offset,
               corner.frac_s, corner.frac_t, corner.same_tile, corner.last_corner};
        if (expected_texels.size() == 0) begin
          report_mismatch("unexpected corner", got.corner_index, -1);
        end else begin
          want = expected_texels.pop_front();
          if (got.corner_index !== want.corner_index)
            report_mismatch("corner_index", got.corner_index, want.corner_index);
          if (got.texel_valid !== want.texel_valid)
            report_mismatch("texel_valid", got.texel_valid, want.texel_valid);
          if (got.tile_origin_x !== want.tile_origin_x)
            report_mismatch("tile_origin_x", got.tile_origin_x, want.tile_origin_x);
          if (got.tile_origin_y !== want.tile_origin_y)
            report_mismatch("tile_origin_y", got.tile_origin_y, want.tile_origin_y);
          if (got.level_out !== want.level_out)
            report_mismatch("level_out", got.level_out, want.level_out);
          if (got.element_offset !== want.element_offset)
            report_mismatch("element_offset", got.element_offset, want.element_offset);
          if (got.frac_s !== want.frac_s)
            report_mismatch("frac_s", got.frac_s, want.frac_s);
          if (got.frac_t !== want.frac_t)
            report_mismatch("frac_t", got.frac_t, want.frac_t);
          if (got.same_tile !== want.same_tile)
            report_mismatch("same_tile", got.same_tile, want.same_tile);
          if (got.last_corner !== want.last_corner)
            report_mismatch("last_corner", got.last_corner, want.last_corner);
        end
      end
      if (lookup.valid && lookup.ready)
        predict_texels(lookup.s_coord, lookup.t_coord, lookup.mip_level);
    end
  end

endmodule

[verif/testbench.sv]
module testbench import twta_pkg::*;;
  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycle;
  int   send_idle;
  int   recv_idle;

  twta_apb_if    apb();
  twta_lookup_if lookup();
  twta_corner_if corner();

  texel_wrap_and_tile_address_core dut (
    .clk(clk), .rst(rst),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
    .paddr(apb.paddr), .pwdata(apb.pwdata), .prdata(apb.prdata), .pready(apb.pready),
    .lookup(lookup.sink), .corner(corner.source)
  );

  twta_checker chk (
    .clk(clk), .rst(rst),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
    .paddr(apb.paddr), .pwdata(apb.pwdata), .pready(apb.pready),
    .lookup(lookup), .corner(corner),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) corner.ready <= 1'b0;
    else corner.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    apb.psel <= 1'b1; apb.penable <= 1'b0; apb.pwrite <= 1'b1;
    apb.paddr <= {idx, 2'b00}; apb.pwdata <= val;
    @(negedge clk);
    apb.penable <= 1'b1;
    do @(posedge clk); while (!apb.pready);
    @(negedge clk);
    apb.psel <= 1'b0; apb.penable <= 1'b0; apb.pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    lookup.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // valid stays high on return; the next send or drain drives it at this edge
  task automatic send_lookup(logic [23:0] s, logic [23:0] t, logic [3:0] lvl);
    while ($urandom_range(99) < send_idle) begin
      lookup.valid <= 1'b0;
      @(negedge clk);
    end
    lookup.valid <= 1'b1; lookup.s_coord <= s; lookup.t_coord <= t;
    lookup.mip_level <= lvl;
    do @(posedge clk); while (!lookup.ready);
    @(negedge clk);
  endtask

  task automatic random_cfg();
    reg_write(REG_BASE_WIDTH, ($urandom_range(3) == 0) ? $urandom_range(32767)
                              : $urandom_range(1, 64));
    reg_write(REG_BASE_HEIGHT, ($urandom_range(3) == 0) ? $urandom_range(32767)
                               : $urandom_range(1, 64));
    reg_write(REG_TILE_W_LOG2, $urandom_range(15));
    reg_write(REG_TILE_H_LOG2, $urandom_range(15));
    reg_write(REG_S_WRAP, $urandom_range(3));
    reg_write(REG_T_WRAP, $urandom_range(3));
    reg_write(REG_CHANNELS, $urandom_range(31));
    reg_write(REG_FIRST_CHAN, $urandom_range(15));
  endtask

  task automatic random_lookup();
    logic [23:0] s, t;
    case ($urandom_range(3))
      0: begin s = 24'($urandom); t = 24'($urandom); end
      default: begin
        s = 24'($signed($urandom_range(0, 196608)) - 65536);
        t = 24'($signed($urandom_range(0, 196608)) - 65536);
      end
    endcase
    send_lookup(s, t, ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                               : 4'($urandom_range(3)));
  endtask

  initial begin
    rst = 1'b1;
    send_idle = 0; recv_idle = 0;
    apb.psel = 0; apb.penable = 0; apb.pwrite = 0; apb.paddr = 0; apb.pwdata = 0;
    lookup.valid = 0; lookup.s_coord = 0; lookup.t_coord = 0; lookup.mip_level = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    send_lookup(24'h000000, 24'h000000, 4'd0);
    send_lookup(24'h7FFFFF, 24'h800000, 4'd15);
    send_lookup(24'h800000, 24'h7FFFFF, 4'd14);
    send_lookup(24'h008000, 24'h00FFFF, 4'd1);
    drain();
    for (int m = 0; m < 4; m++) begin
      reg_write(REG_S_WRAP, m);
      reg_write(REG_T_WRAP, 3 - m);
      reg_write(REG_BASE_WIDTH, (m == 0) ? 32'h7FFF : m * 5);
      reg_write(REG_BASE_HEIGHT, (m == 1) ? 0 : 16384);
      reg_write(REG_TILE_W_LOG2, (m == 2) ? 15 : m);
      reg_write(REG_TILE_H_LOG2, 10 + m);
      reg_write(REG_CHANNELS, (m == 3) ? 31 : 16 * (m & 1) + 1);
      reg_write(REG_FIRST_CHAN, 15 * (m & 1));
      send_lookup(24'hFF0000, 24'h7FFFFF, 4'd0);
      send_lookup(24'h017FFF, 24'hFE8000, 4'd2);
      send_lookup(24'h800000, 24'h000001, 4'd0);
      send_lookup(24'h7FFFFF, 24'h555555, 4'(m * 4));
      drain();
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 29 : (ph == 1) ? 88 : 0;
      recv_idle = (ph == 0) ? 88 : (ph == 1) ? 29 : 0;
      for (int k = 0; k < 3; k++) begin
        random_cfg();
        repeat (29) random_lookup();
        drain();
      end
    end
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
